@@ design/hpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAG_W      = PROD_W;
    localparam int QUO_W      = DATA_W;
    localparam int REM_W      = MAG_W + QUO_W + 1;
    localparam int ROWS       = 4;
    localparam int COLS       = 3;
    localparam int LANES      = 3;
    localparam int DIV_STAGES = QUO_W + 1;

    // Command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_POINT  = 2'd1;
    localparam logic [1:0] CMD_VECTOR = 2'd2;

    // Saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Input word
    typedef struct packed {
        logic [1:0]               cmd;
        logic [3:0]               entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] x_in;
        logic signed [DATA_W-1:0] y_in;
        logic signed [DATA_W-1:0] z_in;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [DATA_W-1:0] x_out;
        logic signed [DATA_W-1:0] y_out;
        logic signed [DATA_W-1:0] z_out;
        logic                     w_zero;
        logic                     overflow;
    } out_word_t;

    // Word carried through the divider pipeline
    typedef struct packed {
        logic                          is_pt;
        logic                          w_zero;
        logic                          vovf;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0]              big;
        logic [LANES-1:0][REM_W-1:0]   rem;
        logic [LANES-1:0][QUO_W-1:0]   quo;
        logic [MAG_W-1:0]              den;
    } div_word_t;

endpackage

@@ design/hpt_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_divider
// Restoring divider pipeline, one quotient bit per stage for three lanes,
// preceded by a stage that flags quotients too large for 32 bits.
// ----------------------------------------------------------------------------
module hpt_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hpt_pkg::div_word_t in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output hpt_pkg::div_word_t out_word
);
    import hpt_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] ready;
    div_word_t             word_reg [DIV_STAGES];
    div_word_t             word_next [DIV_STAGES];

    // One compare-subtract step on every lane
    function automatic div_word_t div_step(input div_word_t d, input logic [4:0] bit_idx);
        div_word_t        o;
        logic [REM_W-1:0] sub;
        o   = d;
        sub = REM_W'(d.den) << bit_idx;
        for (int r = 0; r < LANES; r++)
        begin
            if (d.is_pt && (d.rem[r] >= sub))
            begin
                o.rem[r]          = d.rem[r] - sub;
                o.quo[r][bit_idx] = 1'b1;
            end
        end
        return o;
    endfunction

    // Overflow check stage
    always_comb
    begin
        word_next[0] = in_word;
        for (int r = 0; r < LANES; r++)
        begin
            word_next[0].big[r] = in_word.rem[r] >= REM_W'({in_word.den, {QUO_W{1'b0}}});
        end
    end

    genvar k;
    generate
        for (k = 1; k < DIV_STAGES; k++)
        begin : g_step
            assign word_next[k] = div_step(word_reg[k-1], 5'(QUO_W - k));
        end

        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            // Stage advances when empty or when its successor advances
            if (k == DIV_STAGES - 1)
            begin : g_last
                assign ready[k] = !valid_reg[k] || out_ready;
            end
            else
            begin : g_mid
                assign ready[k] = !valid_reg[k] || ready[k+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ready[k])
                begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[k])
                begin
                    word_reg[k] <= word_next[k];
                end
            end
        end
    endgenerate

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_word  = word_reg[DIV_STAGES-1];

endmodule

@@ design/homogeneous_point_transform.sv @@
`timescale 1ns / 1ps
// Latency: 37 register stages (multiply, sum, prepare, range check, 32 divider
//   steps, output register) from acceptance to res_valid.
// Throughput: one word per cycle while res_stall is low; the 32-step divider pipeline sets the latency.
// Load words update the matrix at acceptance and give no result.
// Reset: matrix returns to the identity, all pipeline stages empty.
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 fixed-point transform of points (with w divide) and direction vectors.
// ----------------------------------------------------------------------------
module homogeneous_point_transform (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  hpt_pkg::in_word_t  cmd_word,
    output logic              res_valid,
    input  logic              res_stall,
    output hpt_pkg::out_word_t res_word
);
    import hpt_pkg::*;

    // Matrix store
    logic signed [DATA_W-1:0] mat_reg [ROWS*4];

    logic signed [DATA_W-1:0] vin [COLS];
    logic                     accept;
    logic                     xform;

    // Stage A: products
    logic                     a_valid_reg;
    logic                     a_pt_reg;
    logic signed [PROD_W-1:0] a_prod_reg [ROWS][COLS];
    logic signed [DATA_W-1:0] a_tr_reg [ROWS];
    logic                     a_ready;

    // Stage B: row sums
    logic                     b_valid_reg;
    logic                     b_pt_reg;
    logic signed [SUM_W-1:0]  b_sum_reg [ROWS];
    logic signed [SUM_W-1:0]  b_sum_next [ROWS];
    logic                     b_ready;

    // Stage C: magnitudes and vector results
    logic                     c_valid_reg;
    div_word_t                c_word_reg;
    div_word_t                c_word_next;
    logic                     c_ready;
    logic signed [SUM_W-1:0]  w_mag;
    logic signed [SUM_W-1:0]  s_mag [LANES];
    logic signed [SUM_W-1:0]  s_sh [LANES];
    logic [LANES-1:0]         s_fits;

    // Divider and output stage
    logic                     div_in_ready;
    logic                     div_valid;
    div_word_t                div_word;
    logic                     out_ready;
    logic                     res_valid_reg;
    out_word_t                res_word_reg;
    out_word_t                res_word_next;
    logic [LANES-1:0][DATA_W-1:0] lane_val;
    logic [LANES-1:0]         lane_sat;

    assign vin[0] = cmd_word.x_in;
    assign vin[1] = cmd_word.y_in;
    assign vin[2] = cmd_word.z_in;

    // Handshake chain
    assign out_ready = !res_valid_reg || !res_stall;
    assign c_ready   = !c_valid_reg || div_in_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign cmd_stall = !a_ready;
    assign accept    = cmd_valid && a_ready;
    assign xform     = (cmd_word.cmd == CMD_POINT) || (cmd_word.cmd == CMD_VECTOR);

    // Matrix loads; identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS*4; i++)
            begin
                mat_reg[i] <= ((i >> 2) == (i & 3)) ? DATA_W'(1 << FRAC_BITS) : '0;
            end
        end
        else if (accept && (cmd_word.cmd == CMD_LOAD))
        begin
            mat_reg[cmd_word.entry_index] <= cmd_word.entry_value;
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= accept && xform;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Stage A: twelve products against the current matrix
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_pt_reg <= (cmd_word.cmd == CMD_POINT);
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    a_prod_reg[r][c] <= PROD_W'(mat_reg[r*4+c]) * PROD_W'(vin[c]);
                end
                a_tr_reg[r] <= mat_reg[r*4+3];
            end
        end
    end

    // Stage B: exact row sums, translation for points
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            b_sum_next[r] = SUM_W'(a_prod_reg[r][0]) + SUM_W'(a_prod_reg[r][1])
                          + SUM_W'(a_prod_reg[r][2])
                          + (a_pt_reg ? (SUM_W'(a_tr_reg[r]) <<< FRAC_BITS) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_pt_reg <= a_pt_reg;
            for (int r = 0; r < ROWS; r++)
            begin
                b_sum_reg[r] <= b_sum_next[r];
            end
        end
    end

    // Stage C: signs and magnitudes for the divide, floor shift for vectors
    always_comb
    begin
        c_word_next        = '0;
        c_word_next.is_pt  = b_pt_reg;
        c_word_next.w_zero = b_pt_reg && (b_sum_reg[3] == '0);
        w_mag              = b_sum_reg[3][SUM_W-1] ? -b_sum_reg[3] : b_sum_reg[3];
        c_word_next.den    = w_mag[MAG_W-1:0];
        for (int r = 0; r < LANES; r++)
        begin
            s_mag[r]  = b_sum_reg[r][SUM_W-1] ? -b_sum_reg[r] : b_sum_reg[r];
            s_sh[r]   = b_sum_reg[r] >>> FRAC_BITS;
            s_fits[r] = (&s_sh[r][SUM_W-1:DATA_W-1]) | ~(|s_sh[r][SUM_W-1:DATA_W-1]);
            c_word_next.neg[r] = b_sum_reg[r][SUM_W-1] ^ b_sum_reg[3][SUM_W-1];
            c_word_next.rem[r] = REM_W'(s_mag[r][MAG_W-1:0]) << FRAC_BITS;
            if (!b_pt_reg)
            begin
                c_word_next.quo[r] = s_fits[r] ? s_sh[r][DATA_W-1:0]
                                   : (b_sum_reg[r][SUM_W-1] ? SAT_MIN : SAT_MAX);
                if (!s_fits[r])
                begin
                    c_word_next.vovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready)
        begin
            c_word_reg <= c_word_next;
        end
    end

    hpt_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_ready  (div_in_ready),
        .in_word   (c_word_reg),
        .out_valid (div_valid),
        .out_ready (out_ready),
        .out_word  (div_word)
    );

    // Output stage: sign, saturation, zero-w handling
    always_comb
    begin
        for (int r = 0; r < LANES; r++)
        begin
            if (div_word.neg[r])
            begin
                lane_sat[r] = div_word.big[r] || (div_word.quo[r] > SAT_MIN);
                lane_val[r] = lane_sat[r] ? SAT_MIN : -div_word.quo[r];
            end
            else
            begin
                lane_sat[r] = div_word.big[r] || div_word.quo[r][QUO_W-1];
                lane_val[r] = lane_sat[r] ? SAT_MAX : div_word.quo[r];
            end
        end
        res_word_next = '0;
        if (!div_word.is_pt)
        begin
            res_word_next.x_out    = div_word.quo[0];
            res_word_next.y_out    = div_word.quo[1];
            res_word_next.z_out    = div_word.quo[2];
            res_word_next.overflow = div_word.vovf;
        end
        else if (div_word.w_zero)
        begin
            res_word_next.w_zero = 1'b1;
        end
        else
        begin
            res_word_next.x_out    = lane_val[0];
            res_word_next.y_out    = lane_val[1];
            res_word_next.z_out    = lane_val[2];
            res_word_next.overflow = |lane_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            res_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            res_word_reg <= res_word_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
